FILE: sv/slvc_pkg.sv
// ----------------------------------------------------------------------------
// slvc_pkg
// Shared widths, codes and helper functions of the staircase landing
// velocity controller.
// ----------------------------------------------------------------------------
package slvc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // shift-add multiplier: a up to 50 bits, b up to 17 bits
  localparam int MUL_A_W = 50;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  // restoring divider: 48-bit dividend, 33-bit divisor
  localparam int DIV_N_W = 48;
  localparam int DIV_D_W = 33;
  localparam int MD_CNT_W = $clog2(DIV_N_W);
  // digit-by-digit square root
  localparam int SQ_IN_W  = 64;
  localparam int SQ_OUT_W = SQ_IN_W / 2;
  localparam int SQ_CNT_W = $clog2(SQ_OUT_W);

  localparam int VEL_LIMIT         = 32767;
  localparam int ASCENT_SPEED_MM_S = 200;
  localparam int CONE_FAR_MM       = 2500;
  localparam int CONE_R2_MM2       = 1000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DESCENT_STEP  = 3'd0,
    REG_Z_GAIN        = 3'd1,
    REG_DONE_THRESH   = 3'd2,
    REG_SAFE_REF_ALT  = 3'd3,
    REG_SAFE_ASC_ALT  = 3'd4,
    REG_XY_GAIN       = 3'd5,
    REG_XY_SPEED_MAX  = 3'd6,
    REG_MARKER_TMO    = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_RUNNING = 2'd0,
    ST_SUCCESS = 2'd1,
    ST_FAILURE = 2'd2
  } status_e;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } md_op_e;

  // divide by 256, round to nearest, ties away from zero (on a magnitude)
  function automatic logic [MUL_P_W-1:0] round_q8(input logic [MUL_P_W-1:0] p);
    return (p + MUL_P_W'(128)) >> 8;
  endfunction

  function automatic logic signed [15:0] sat_vel(input logic [MUL_P_W-1:0] mag,
                                                 input logic neg);
    logic [15:0] m;
    if (mag > MUL_P_W'(VEL_LIMIT)) m = 16'(VEL_LIMIT);
    else m = mag[15:0];
    return neg ? -$signed(m) : $signed(m);
  endfunction

endpackage

FILE: sv/slvc_if.sv
// ----------------------------------------------------------------------------
// slvc_in_if / slvc_out_if
// Valid/ready channels carrying one control step and one command word.
// ----------------------------------------------------------------------------
interface slvc_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic               marker_seen;
  logic [15:0]        elapsed_ms;
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic signed [16:0] dz;

  modport source (output valid, func, marker_seen, elapsed_ms, dx, dy, dz, input ready);
  modport sink   (input valid, func, marker_seen, elapsed_ms, dx, dy, dz, output ready);
endinterface

interface slvc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic signed [15:0] vel_z;
  logic [1:0]         status;
  logic [16:0]        dist_xy;
  logic signed [16:0] dist_z;

  modport source (output valid, vel_x, vel_y, vel_z, status, dist_xy, dist_z, input ready);
  modport sink   (input valid, vel_x, vel_y, vel_z, status, dist_xy, dist_z, output ready);
endinterface

FILE: sv/slvc_muldiv.sv
// ----------------------------------------------------------------------------
// slvc_muldiv
// Bit-serial unsigned multiplier (shift-add) and restoring divider.
// ----------------------------------------------------------------------------
module slvc_muldiv (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  slvc_pkg::md_op_e                op_i,
  input  logic [slvc_pkg::MUL_A_W-1:0]    a_i,
  input  logic [slvc_pkg::DIV_D_W-1:0]    b_i,
  output logic                            done_o,
  output logic [slvc_pkg::MUL_P_W-1:0]    res_o
);
  import slvc_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  md_op_e              op_q, op_d;
  logic [MD_CNT_W-1:0] cnt_q, cnt_d;
  logic [MUL_P_W-1:0]  acc_q, acc_d;
  logic [MUL_P_W-1:0]  sh_q, sh_d;
  logic [DIV_D_W-1:0]  b_q, b_d;
  logic [DIV_D_W-1:0]  rem_q, rem_d;
  logic [DIV_D_W:0]    tr, tr_sub;
  logic                ge, last;

  always_comb begin
    tr     = {rem_q, sh_q[DIV_N_W-1]};
    tr_sub = tr - {1'b0, b_q};
    ge     = tr >= {1'b0, b_q};
    last   = (op_q == OP_MUL) ? (cnt_q == MD_CNT_W'(MUL_B_W - 1))
                              : (cnt_q == MD_CNT_W'(DIV_N_W - 1));
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    sh_d   = sh_q;
    b_d    = b_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      op_d   = op_i;
      cnt_d  = '0;
      acc_d  = '0;
      sh_d   = MUL_P_W'(a_i);
      b_d    = b_i;
      rem_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + MD_CNT_W'(1);
      unique case (op_q)
        OP_MUL: begin
          if (b_q[0]) acc_d = acc_q + sh_q;
          sh_d = sh_q << 1;
          b_d  = b_q >> 1;
        end
        OP_DIV: begin
          // quotient bits shift in from the bottom as dividend bits leave the top
          rem_d = ge ? tr_sub[DIV_D_W-1:0] : tr[DIV_D_W-1:0];
          sh_d  = {sh_q[MUL_P_W-2:0], ge};
        end
        default: ;
      endcase
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sh_q  <= sh_d;
    b_q   <= b_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign res_o  = (op_q == OP_MUL) ? acc_q : MUL_P_W'(sh_q[DIV_N_W-1:0]);

endmodule

FILE: sv/slvc_isqrt.sv
// ----------------------------------------------------------------------------
// slvc_isqrt
// Floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module slvc_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [slvc_pkg::SQ_IN_W-1:0]  rad_i,
  output logic                          done_o,
  output logic [slvc_pkg::SQ_OUT_W-1:0] root_o
);
  import slvc_pkg::*;

  localparam int REM_W = SQ_OUT_W + 2;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [SQ_CNT_W-1:0] cnt_q, cnt_d;
  logic [SQ_IN_W-1:0]  rad_q, rad_d;
  logic [REM_W-1:0]    rem_q, rem_d;
  logic [SQ_OUT_W-1:0] root_q, root_d;
  logic [REM_W+1:0]    tr, trial, tr_sub;
  logic                ge;

  always_comb begin
    tr     = {rem_q, rad_q[SQ_IN_W-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};
    tr_sub = tr - trial;
    ge     = tr >= trial;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      cnt_d  = cnt_q + SQ_CNT_W'(1);
      rad_d  = rad_q << 2;
      rem_d  = ge ? tr_sub[REM_W-1:0] : tr[REM_W-1:0];
      root_d = {root_q[SQ_OUT_W-2:0], ge};
      if (cnt_q == SQ_CNT_W'(SQ_OUT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: sv/staircase_landing_velocity_ctrl_core.sv
// ----------------------------------------------------------------------------
// staircase_landing_velocity_ctrl_core
// Landing velocity controller: marker timeout, staircase descent in the
// cone, clamped XY approach outside it.
// ----------------------------------------------------------------------------
// One step word is taken at a time and gives one command word. A restart or
// a step without marker goes straight to the output state. A step with a
// marker runs through a sequencer over one bit-serial multiplier / divider
// and one square root unit. Landing done ends after the first square root;
// near the ground the cone test also needs dz^2, and outside the cone, when
// the XY speed is clamped, the step takes two 64-bit square roots and two
// divides. A finished word waits in the output register while the next
// step word is taken.
module staircase_landing_velocity_ctrl_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  slvc_in_if.sink                            in_i,
  slvc_out_if.source                         out_o,
  input  logic                               cfg_we_i,
  input  logic [slvc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [slvc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import slvc_pkg::*;

  typedef enum logic [21:0] {
    S_IDLE  = 22'h000001,
    S_SQX   = 22'h000002,
    S_SQY   = 22'h000004,
    S_ROOT  = 22'h000008,
    S_SQZ   = 22'h000010,
    S_CONE  = 22'h000020,
    S_REF1  = 22'h000040,
    S_REF2  = 22'h000080,
    S_VZIN  = 22'h000100,
    S_OUTV  = 22'h000200,
    S_VZOUT = 22'h000400,
    S_SG    = 22'h000800,
    S_SGG   = 22'h001000,
    S_VV    = 22'h002000,
    S_XG    = 22'h004000,
    S_YG    = 22'h008000,
    S_RSQ   = 22'h010000,
    S_XV    = 22'h020000,
    S_XD    = 22'h040000,
    S_YV    = 22'h080000,
    S_YD    = 22'h100000,
    S_OUT   = 22'h200000
  } state_e;

  // configuration
  logic [15:0] step_q, gz_q, thr_q, safe_q, asc_q, gxy_q;
  logic [14:0] vmax_q;
  logic [19:0] tmo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 16'd300;
      gz_q   <= 16'd256;
      thr_q  <= 16'd100;
      safe_q <= 16'd3500;
      asc_q  <= 16'd3000;
      gxy_q  <= 16'd256;
      vmax_q <= 15'd1000;
      tmo_q  <= 20'd2000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_DESCENT_STEP: step_q <= cfg_wdata_i[15:0];
        REG_Z_GAIN:       gz_q   <= cfg_wdata_i[15:0];
        REG_DONE_THRESH:  thr_q  <= cfg_wdata_i[15:0];
        REG_SAFE_REF_ALT: safe_q <= cfg_wdata_i[15:0];
        REG_SAFE_ASC_ALT: asc_q  <= cfg_wdata_i[15:0];
        REG_XY_GAIN:      gxy_q  <= cfg_wdata_i[15:0];
        REG_XY_SPEED_MAX: vmax_q <= cfg_wdata_i[14:0];
        REG_MARKER_TMO:   tmo_q  <= cfg_wdata_i[19:0];
        default: ;
      endcase
    end
  end

  state_e             st_q, st_d;
  logic               kick_q, kick_d;
  logic               need_q, need_d;
  logic signed [17:0] ref_q, ref_d;
  logic [19:0]        tmr_q, tmr_d;
  logic               ov_q, ov_d;

  logic               dxn_q, dxn_d, dyn_q, dyn_d;
  logic [16:0]        ax_q, ax_d, ay_q, ay_d, adz_q, adz_d;
  logic [33:0]        s_q, s_d, az2_q, az2_d;
  logic [MUL_A_W-1:0] t_q, t_d;
  logic [65:0]        pg_q, pg_d;
  logic [SQ_OUT_W-1:0] r_q, r_d;
  logic [DIV_N_W-1:0] num_q, num_d;
  logic signed [15:0] vx_q, vx_d, vy_q, vy_d, vz_q, vz_d;
  status_e            status_q, status_d;
  logic [16:0]        dxy_q, dxy_d;
  logic signed [16:0] dzo_q, dzo_d;

  logic signed [15:0] o_vx_q, o_vy_q, o_vz_q;
  logic [1:0]         o_st_q;
  logic [16:0]        o_dxy_q;
  logic signed [16:0] o_dz_q;
  logic               load_out;

  // arithmetic units
  logic               md_start, md_done;
  md_op_e             md_op;
  logic [MUL_A_W-1:0] md_a;
  logic [DIV_D_W-1:0] md_b;
  logic [MUL_P_W-1:0] md_res;
  logic               sq_start, sq_done;
  logic [SQ_IN_W-1:0] sq_rad;
  logic [SQ_OUT_W-1:0] sq_root;

  slvc_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .op_i    (md_op),
    .a_i     (md_a),
    .b_i     (md_b),
    .done_o  (md_done),
    .res_o   (md_res)
  );

  slvc_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sq_rad),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  logic signed [18:0] diff_in;
  logic [16:0]        mag_in;
  logic signed [17:0] diff_out;
  logic [16:0]        mag_out;
  logic [38:0]        s25;
  logic [20:0]        tsum;
  logic [19:0]        tnew;
  logic [16:0]        in_ax, in_ay, in_az;

  always_comb begin
    diff_in  = {ref_q[17], ref_q} - {2'b00, adz_q};
    mag_in   = diff_in[18] ? 17'(-diff_in) : diff_in[16:0];
    diff_out = {2'b00, safe_q} - {1'b0, adz_q};
    mag_out  = diff_out[17] ? 17'(-diff_out) : diff_out[16:0];
    s25      = {1'b0, s_q, 4'b0} + {2'b0, s_q, 3'b0} + {5'b0, s_q};
    tsum     = {1'b0, tmr_q} + {5'b0, in_i.elapsed_ms};
    tnew     = tsum[20] ? '1 : tsum[19:0];
    in_ax    = in_i.dx[16] ? 17'(-in_i.dx) : in_i.dx;
    in_ay    = in_i.dy[16] ? 17'(-in_i.dy) : in_i.dy;
    in_az    = in_i.dz[16] ? 17'(-in_i.dz) : in_i.dz;
  end

  // operand selection for the unit the current state runs
  always_comb begin
    md_op  = OP_MUL;
    md_a   = '0;
    md_b   = '0;
    sq_rad = '0;
    unique case (st_q)
      S_SQX:   begin md_a = MUL_A_W'(ax_q);    md_b = DIV_D_W'(ax_q);   end
      S_SQY:   begin md_a = MUL_A_W'(ay_q);    md_b = DIV_D_W'(ay_q);   end
      S_SQZ:   begin md_a = MUL_A_W'(adz_q);   md_b = DIV_D_W'(adz_q);  end
      S_VZIN:  begin md_a = MUL_A_W'(mag_in);  md_b = DIV_D_W'(gz_q);   end
      S_VZOUT: begin md_a = MUL_A_W'(mag_out); md_b = DIV_D_W'(gz_q);   end
      S_SG:    begin md_a = MUL_A_W'(s_q);     md_b = DIV_D_W'(gxy_q);  end
      S_SGG:   begin md_a = t_q;               md_b = DIV_D_W'(gxy_q);  end
      S_VV:    begin md_a = MUL_A_W'(vmax_q);  md_b = DIV_D_W'(vmax_q); end
      S_XG:    begin md_a = MUL_A_W'(ax_q);    md_b = DIV_D_W'(gxy_q);  end
      S_YG:    begin md_a = MUL_A_W'(ay_q);    md_b = DIV_D_W'(gxy_q);  end
      S_XV:    begin md_a = MUL_A_W'(ax_q);    md_b = DIV_D_W'(vmax_q); end
      S_YV:    begin md_a = MUL_A_W'(ay_q);    md_b = DIV_D_W'(vmax_q); end
      S_XD, S_YD: begin
        md_op = OP_DIV;
        md_a  = MUL_A_W'(num_q);
        md_b  = DIV_D_W'(r_q);
      end
      S_ROOT:  sq_rad = SQ_IN_W'(s_q);
      S_RSQ:   sq_rad = {s_q, 30'b0};
      default: ;
    endcase
    md_start = kick_q && st_q != S_IDLE && st_q != S_ROOT &&
               st_q != S_RSQ && st_q != S_CONE && st_q != S_REF1 &&
               st_q != S_REF2 && st_q != S_OUTV && st_q != S_OUT;
    sq_start = kick_q && (st_q == S_ROOT || st_q == S_RSQ);
  end

  always_comb begin
    st_d     = st_q;
    need_d   = need_q;
    ref_d    = ref_q;
    tmr_d    = tmr_q;
    dxn_d    = dxn_q;
    dyn_d    = dyn_q;
    ax_d     = ax_q;
    ay_d     = ay_q;
    adz_d    = adz_q;
    s_d      = s_q;
    az2_d    = az2_q;
    t_d      = t_q;
    pg_d     = pg_q;
    r_d      = r_q;
    num_d    = num_q;
    vx_d     = vx_q;
    vy_d     = vy_q;
    vz_d     = vz_q;
    status_d = status_q;
    dxy_d    = dxy_q;
    dzo_d    = dzo_q;
    load_out = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (in_i.valid) begin
          vx_d     = '0;
          vy_d     = '0;
          vz_d     = '0;
          status_d = ST_RUNNING;
          dxy_d    = '0;
          dzo_d    = '0;
          if (in_i.func) begin
            ref_d  = '0;
            need_d = 1'b1;
            tmr_d  = '0;
            st_d   = S_OUT;
          end else if (!in_i.marker_seen) begin
            tmr_d = tnew;
            if (tnew > tmo_q) status_d = ST_FAILURE;
            st_d  = S_OUT;
          end else begin
            tmr_d = '0;
            dxn_d = in_i.dx[16];
            dyn_d = in_i.dy[16];
            ax_d  = in_ax;
            ay_d  = in_ay;
            adz_d = in_az;
            dzo_d = in_i.dz;
            st_d  = S_SQX;
          end
        end
      end
      S_SQX: if (md_done) begin
        s_d  = md_res[33:0];
        st_d = S_SQY;
      end
      S_SQY: if (md_done) begin
        s_d  = s_q + md_res[33:0];
        st_d = S_ROOT;
      end
      S_ROOT: if (sq_done) begin
        dxy_d = sq_root[16:0];
        if (adz_q < {1'b0, thr_q}) begin
          status_d = ST_SUCCESS;
          st_d     = S_OUT;
        end else if (adz_q > 17'(CONE_FAR_MM)) begin
          st_d = (s_q <= 34'(CONE_R2_MM2)) ? S_REF1 : S_OUTV;
        end else begin
          st_d = S_SQZ;
        end
      end
      S_SQZ: if (md_done) begin
        az2_d = md_res[33:0];
        st_d  = S_CONE;
      end
      // near the ground: inside when 25*r^2 <= 4*dz^2
      S_CONE: st_d = (s25 <= {3'b0, az2_q, 2'b0}) ? S_REF1 : S_OUTV;
      S_REF1: begin
        if (need_q) begin
          ref_d  = {1'b0, adz_q} - {2'b0, step_q};
          need_d = 1'b0;
        end
        st_d = S_REF2;
      end
      S_REF2: begin
        if ($signed({1'b0, adz_q}) <= ref_q) ref_d = ref_q - $signed({2'b0, step_q});
        st_d = S_VZIN;
      end
      S_VZIN: if (md_done) begin
        vz_d = sat_vel(round_q8(md_res), diff_in[18]);
        st_d = S_OUT;
      end
      S_OUTV: begin
        need_d = 1'b1;
        if (adz_q < {1'b0, asc_q}) begin
          vz_d = 16'(ASCENT_SPEED_MM_S);
          st_d = S_SG;
        end else begin
          st_d = S_VZOUT;
        end
      end
      S_VZOUT: if (md_done) begin
        vz_d = sat_vel(round_q8(md_res), diff_out[17]);
        st_d = S_SG;
      end
      S_SG: if (md_done) begin
        t_d  = md_res[MUL_A_W-1:0];
        st_d = S_SGG;
      end
      S_SGG: if (md_done) begin
        pg_d = md_res[65:0];
        st_d = S_VV;
      end
      // clamp when g^2 * r^2 > (256 * vmax)^2
      S_VV: if (md_done) begin
        st_d = (pg_q > {20'b0, md_res[29:0], 16'b0}) ? S_RSQ : S_XG;
      end
      S_XG: if (md_done) begin
        vx_d = sat_vel(round_q8(md_res), dxn_q);
        st_d = S_YG;
      end
      S_YG: if (md_done) begin
        vy_d = sat_vel(round_q8(md_res), dyn_q);
        st_d = S_OUT;
      end
      S_RSQ: if (sq_done) begin
        r_d  = sq_root;
        st_d = S_XV;
      end
      S_XV, S_YV: if (md_done) begin
        num_d = {1'b0, md_res[31:0], 15'b0} + DIV_N_W'(r_q >> 1);
        st_d  = (st_q == S_XV) ? S_XD : S_YD;
      end
      S_XD: if (md_done) begin
        vx_d = sat_vel(md_res, dxn_q);
        st_d = S_YV;
      end
      S_YD: if (md_done) begin
        vy_d = sat_vel(md_res, dyn_q);
        st_d = S_OUT;
      end
      S_OUT: if (!ov_q || out_o.ready) begin
        load_out = 1'b1;
        st_d     = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
    kick_d = (st_d != st_q);
    ov_d   = load_out | (ov_q & ~out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      kick_q <= 1'b0;
      need_q <= 1'b1;
      ref_q  <= '0;
      tmr_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      kick_q <= kick_d;
      need_q <= need_d;
      ref_q  <= ref_d;
      tmr_q  <= tmr_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dxn_q    <= dxn_d;
    dyn_q    <= dyn_d;
    ax_q     <= ax_d;
    ay_q     <= ay_d;
    adz_q    <= adz_d;
    s_q      <= s_d;
    az2_q    <= az2_d;
    t_q      <= t_d;
    pg_q     <= pg_d;
    r_q      <= r_d;
    num_q    <= num_d;
    vx_q     <= vx_d;
    vy_q     <= vy_d;
    vz_q     <= vz_d;
    status_q <= status_d;
    dxy_q    <= dxy_d;
    dzo_q    <= dzo_d;
    if (load_out) begin
      o_vx_q  <= vx_q;
      o_vy_q  <= vy_q;
      o_vz_q  <= vz_q;
      o_st_q  <= status_q;
      o_dxy_q <= dxy_q;
      o_dz_q  <= dzo_q;
    end
  end

  assign in_i.ready    = (st_q == S_IDLE);
  assign out_o.valid   = ov_q;
  assign out_o.vel_x   = o_vx_q;
  assign out_o.vel_y   = o_vy_q;
  assign out_o.vel_z   = o_vz_q;
  assign out_o.status  = o_st_q;
  assign out_o.dist_xy = o_dxy_q;
  assign out_o.dist_z  = o_dz_q;

endmodule

FILE: sv/slvc_checker.sv
// ----------------------------------------------------------------------------
// slvc_checker
// Port-level checks of the landing controller, bound to the top level.
// ----------------------------------------------------------------------------
module slvc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [15:0] vel_x_i,
  input logic signed [15:0] vel_y_i,
  input logic signed [15:0] vel_z_i,
  input logic [1:0]         status_i,
  input logic [16:0]        dist_xy_i,
  input logic signed [16:0] dist_z_i
);
  import slvc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("command word dropped while stalled");

  // one step word in flight at a time
  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("step word taken while busy");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (status_i == ST_RUNNING || status_i == ST_SUCCESS ||
                     status_i == ST_FAILURE))
    else $error("bad status code");

  a_success_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_SUCCESS |->
      vel_x_i == 16'sd0 && vel_y_i == 16'sd0 && vel_z_i == 16'sd0)
    else $error("motion commanded on success");

  a_failure_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_FAILURE |->
      vel_x_i == 16'sd0 && vel_y_i == 16'sd0 && vel_z_i == 16'sd0 &&
      dist_xy_i == 17'd0 && dist_z_i == 17'sd0)
    else $error("nonzero word on marker timeout");

endmodule

bind staircase_landing_velocity_ctrl_core slvc_checker u_slvc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .vel_x_i     (out_o.vel_x),
  .vel_y_i     (out_o.vel_y),
  .vel_z_i     (out_o.vel_z),
  .status_i    (out_o.status),
  .dist_xy_i   (out_o.dist_xy),
  .dist_z_i    (out_o.dist_z)
);

FILE: sim/tb_staircase_landing_velocity_ctrl_core.sv
// ----------------------------------------------------------------------------
// tb_staircase_landing_velocity_ctrl_core
// Self-checking bench: directed table then random control steps, checked
// against an in-bench model of the staircase landing controller.
// ----------------------------------------------------------------------------
module tb_staircase_landing_velocity_ctrl_core;
  timeunit 1ns;
  timeprecision 1ps;
  import slvc_pkg::*;

  typedef struct {
    logic               func;
    logic               seen;
    logic [15:0]        elapsed;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [16:0] dz;
  } step_t;

  typedef struct {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
    status_e            status;
    logic [16:0]        dxy;
    logic signed [16:0] dzo;
  } cmd_t;

  typedef struct {
    step_t stim;
    logic  known;
    cmd_t  cmd;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  slvc_in_if  in_ch ();
  slvc_out_if out_ch ();

  staircase_landing_velocity_ctrl_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // bench copy of registers and state
  longint unsigned cfg_q[8];
  longint          stair_ref;
  bit              first_step;
  longint unsigned dark_ms;

  cmd_t cmd_q[$];
  int   n_err = 0;
  int   hold_cycles = 0;

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint div_near(longint num, longint unsigned den);
    longint unsigned m = (num < 0) ? -num : num;
    longint unsigned q = (m + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clip_vel(longint v);
    if (v > VEL_LIMIT) return VEL_LIMIT;
    if (v < -VEL_LIMIT) return -VEL_LIMIT;
    return v;
  endfunction

  function automatic cmd_t landing_cmd(step_t s);
    cmd_t c;
    longint dx, dy, dz, adz, vx, vy, vz;
    longint unsigned sq, g, vm, g2, lim2, r;
    bit in_cone;
    c = '{0, 0, 0, ST_RUNNING, 0, 0};
    vx = 0; vy = 0; vz = 0;
    if (s.func) begin
      stair_ref = 0;
      first_step = 1;
      dark_ms = 0;
    end else if (!s.seen) begin
      dark_ms += s.elapsed;
      if (dark_ms > 20'hFFFFF) dark_ms = 20'hFFFFF;
      if (dark_ms > cfg_q[REG_MARKER_TMO]) c.status = ST_FAILURE;
    end else begin
      dark_ms = 0;
      dx = s.dx; dy = s.dy; dz = s.dz;
      adz = dz < 0 ? -dz : dz;
      sq = dx * dx + dy * dy;
      c.dxy = 17'(root_floor(sq));
      c.dzo = s.dz;
      if (adz < cfg_q[REG_DONE_THRESH]) begin
        c.status = ST_SUCCESS;
      end else begin
        if (adz > CONE_FAR_MM) in_cone = sq <= CONE_R2_MM2;
        else in_cone = 25 * sq <= 4 * adz * adz;
        if (in_cone) begin
          if (first_step) begin
            stair_ref = adz - longint'(cfg_q[REG_DESCENT_STEP]);
            first_step = 0;
          end
          if (adz <= stair_ref) stair_ref -= cfg_q[REG_DESCENT_STEP];
          vz = clip_vel(div_near((stair_ref - adz) * longint'(cfg_q[REG_Z_GAIN]), 256));
        end else begin
          g = cfg_q[REG_XY_GAIN];
          vm = cfg_q[REG_XY_SPEED_MAX];
          g2 = g * g;
          lim2 = (vm * 256) * (vm * 256);
          if (g2 != 0 && sq > lim2 / g2) begin
            r = root_floor(sq << 30);
            vx = div_near(dx * longint'(vm) * 32768, r);
            vy = div_near(dy * longint'(vm) * 32768, r);
          end else begin
            vx = div_near(dx * longint'(g), 256);
            vy = div_near(dy * longint'(g), 256);
          end
          vx = clip_vel(vx);
          vy = clip_vel(vy);
          first_step = 1;
          if (adz < cfg_q[REG_SAFE_ASC_ALT]) vz = ASCENT_SPEED_MM_S;
          else vz = clip_vel(div_near((longint'(cfg_q[REG_SAFE_REF_ALT]) - adz) *
                                      longint'(cfg_q[REG_Z_GAIN]), 256));
        end
      end
    end
    c.vx = 16'(vx); c.vy = 16'(vy); c.vz = 16'(vz);
    return c;
  endfunction

  task automatic report_err(string what, longint got, longint want);
    $display("error @%0t: %s got %0d want %0d", $realtime, what, got, want);
    n_err++;
  endtask

  task automatic write_reg(cfg_idx_e idx, longint unsigned val);
    longint unsigned mask;
    mask = (idx == REG_MARKER_TMO) ? 20'hFFFFF : (idx == REG_XY_SPEED_MAX) ? 16'h7FFF : 16'hFFFF;
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= CFG_DATA_W'(val);
    cfg_q[idx] = val & mask;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain_wait();
    in_ch.valid <= 1'b0;
    while (cmd_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  // valid stays up after an accept until the next word or an idle stretch
  task automatic send_step(step_t s, int gap, bit known, cmd_t want);
    cmd_t c;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= s.func;
    in_ch.marker_seen <= s.seen;
    in_ch.elapsed_ms <= s.elapsed;
    in_ch.dx <= s.dx;
    in_ch.dy <= s.dy;
    in_ch.dz <= s.dz;
    do @(posedge clk_i); while (!in_ch.ready);
    c = landing_cmd(s);
    if (known && c != want) report_err("directed row vs model", c.vz, want.vz);
    cmd_q.push_back(c);
  endtask

  function automatic logic signed [16:0] rnd_off(int kind);
    case (kind)
      0: return 17'($urandom);
      1: return 17'($signed($urandom_range(0, 6000)) - 3000);
      default: return 17'($signed($urandom_range(0, 600)) - 300);
    endcase
  endfunction

  function automatic step_t rnd_step();
    step_t s;
    int k;
    s.func = ($urandom_range(0, 39) == 0);
    s.seen = ($urandom_range(0, 5) != 0);
    s.elapsed = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200));
    k = $urandom_range(0, 2);
    s.dz = rnd_off(k);
    // mostly near the cone so the staircase runs
    if ($urandom_range(0, 2) != 0) begin
      s.dz = 17'($signed($urandom_range(0, 5000)));
      s.dx = 17'($signed($urandom_range(0, 800)) - 400);
      s.dy = 17'($signed($urandom_range(0, 800)) - 400);
    end else begin
      s.dx = rnd_off(k);
      s.dy = rnd_off(k);
    end
    return s;
  endfunction

  // result side
  always @(posedge clk_i) begin
    cmd_t w;
    if (out_ch.valid && out_ch.ready) begin
      if (cmd_q.size() == 0) begin
        report_err("word with nothing expected", out_ch.vel_z, 0);
      end else begin
        w = cmd_q.pop_front();
        if (out_ch.vel_x !== w.vx) report_err("vel_x", out_ch.vel_x, w.vx);
        if (out_ch.vel_y !== w.vy) report_err("vel_y", out_ch.vel_y, w.vy);
        if (out_ch.vel_z !== w.vz) report_err("vel_z", out_ch.vel_z, w.vz);
        if (out_ch.status !== w.status) report_err("status", out_ch.status, w.status);
        if (out_ch.dist_xy !== w.dxy) report_err("dist_xy", out_ch.dist_xy, w.dxy);
        if (out_ch.dist_z !== w.dzo) report_err("dist_z", out_ch.dist_z, w.dzo);
      end
    end
  end

  // receiver stalls, with a long forced hold-off when requested
  initial begin
    int w;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else if ($urandom_range(0, 3) == 0) begin
        w = $urandom_range(0, 16);
        if (w > 0) begin
          out_ch.ready <= 1'b0;
          repeat (w) @(posedge clk_i);
        end
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #40ms;
    $display("staircase_landing_velocity_ctrl_core: mismatch");
    $finish;
  end

  initial begin
    row_t rows[$];
    step_t s;
    cmd_t z;
    int gap;
    z = '{0, 0, 0, ST_RUNNING, 0, 0};
    in_ch.valid = 1'b0;
    in_ch.func = 1'b0;
    in_ch.marker_seen = 1'b0;
    in_ch.elapsed_ms = '0;
    in_ch.dx = '0;
    in_ch.dy = '0;
    in_ch.dz = '0;
    cfg_q = '{300, 256, 100, 3500, 3000, 256, 1000, 2000};
    stair_ref = 0;
    first_step = 1;
    dark_ms = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed table
    rows.push_back('{'{1, 0, 0, 0, 0, 0}, 1, z});
    rows.push_back('{'{0, 0, 1000, 0, 0, 0}, 1, z});
    rows.push_back('{'{0, 0, 1000, 0, 0, 0}, 1, z});
    rows.push_back('{'{0, 0, 16'hFFFF, 0, 0, 0}, 1, '{0, 0, 0, ST_FAILURE, 0, 0}});
    rows.push_back('{'{0, 1, 0, 0, 0, 50}, 1, '{0, 0, 0, ST_SUCCESS, 0, 50}});
    rows.push_back('{'{0, 1, 0, 3, 4, -17'sd50}, 1, '{0, 0, 0, ST_SUCCESS, 5, -17'sd50}});
    rows.push_back('{'{0, 1, 0, 0, 0, 2000}, 0, z});
    rows.push_back('{'{0, 1, 0, 0, 0, 1700}, 0, z});
    rows.push_back('{'{0, 1, 0, 100, 0, 1400}, 0, z});
    rows.push_back('{'{0, 1, 0, 0, 0, -17'sd2600}, 0, z});
    rows.push_back('{'{0, 1, 0, 1000, 0, 3000}, 0, z});
    rows.push_back('{'{0, 1, 0, 1001, 0, 3000}, 0, z});
    rows.push_back('{'{0, 1, 0, 200, 0, 500}, 0, z});
    rows.push_back('{'{0, 1, 0, 50, 50, 5000}, 0, z});
    rows.push_back('{'{0, 1, 0, 400, 300, 1000}, 0, z});
    rows.push_back('{'{0, 1, 0, -17'sd65536, -17'sd65536, -17'sd65536}, 0, z});
    rows.push_back('{'{0, 1, 0, 65535, 65535, 65535}, 0, z});
    rows.push_back('{'{0, 1, 0, 65535, -17'sd65536, 0}, 0, z});
    rows.push_back('{'{0, 1, 16'hFFFF, 10, -17'sd10, 200}, 0, z});
    rows.push_back('{'{1, 1, 16'hFFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF}, 1, z});
    foreach (rows[i]) send_step(rows[i].stim, $urandom_range(0, 3), rows[i].known,
                                rows[i].cmd);
    drain_wait();

    // phases through register settings; extremes first
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_DESCENT_STEP, 1); write_reg(REG_Z_GAIN, 0);
          write_reg(REG_DONE_THRESH, 0); write_reg(REG_SAFE_REF_ALT, 0);
          write_reg(REG_SAFE_ASC_ALT, 0); write_reg(REG_XY_GAIN, 0);
          write_reg(REG_XY_SPEED_MAX, 0); write_reg(REG_MARKER_TMO, 0);
        end
        1: begin
          write_reg(REG_DESCENT_STEP, 16'hFFFF); write_reg(REG_Z_GAIN, 16'hFFFF);
          write_reg(REG_DONE_THRESH, 16'hFFFF); write_reg(REG_SAFE_REF_ALT, 16'hFFFF);
          write_reg(REG_SAFE_ASC_ALT, 16'hFFFF); write_reg(REG_XY_GAIN, 16'hFFFF);
          write_reg(REG_XY_SPEED_MAX, 16'h7FFF); write_reg(REG_MARKER_TMO, 20'hFFFFF);
        end
        2: begin
          write_reg(REG_DONE_THRESH, 0); write_reg(REG_SAFE_ASC_ALT, 0);
        end
        default: begin
          write_reg(REG_DESCENT_STEP, $urandom_range(1, 600));
          write_reg(REG_Z_GAIN, $urandom_range(0, 1200));
          write_reg(REG_DONE_THRESH, $urandom_range(0, 200));
          write_reg(REG_SAFE_REF_ALT, $urandom_range(0, 65535));
          write_reg(REG_SAFE_ASC_ALT, $urandom_range(0, 5000));
          write_reg(REG_XY_GAIN, $urandom());
          write_reg(REG_XY_SPEED_MAX, $urandom_range(0, 32767));
          write_reg(REG_MARKER_TMO, $urandom_range(0, 3000));
        end
      endcase
      for (int n = 0; n < 200; n++) begin
        s = rnd_step();
        gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
        if (n == 60) begin
          hold_cycles = 3000;
        end
        if (n == 120) begin
          in_ch.valid <= 1'b0;
          while (cmd_q.size() != 0) @(posedge clk_i);
        end
        send_step(s, gap, 0, z);
      end
      drain_wait();
    end

    if (n_err == 0) begin
      $display("staircase_landing_velocity_ctrl_core: match");
    end else begin
      $display("staircase_landing_velocity_ctrl_core: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/slvc_pkg.sv
sv/slvc_if.sv
sv/slvc_muldiv.sv
sv/slvc_isqrt.sv
sv/staircase_landing_velocity_ctrl_core.sv
sv/slvc_checker.sv
sim/tb_staircase_landing_velocity_ctrl_core.sv
